### design/crc32_pkg.sv
package crc32_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] POLY_RESET   = 32'h1EDC_6F41;

  typedef logic [CrcWidth-1:0]  crc_word_t;
  typedef logic [ByteWidth-1:0] crc_byte_t;

  // bit order swap, plain wiring
  function automatic crc_word_t reverse32(input crc_word_t v);
    crc_word_t r;
    r = '0;
    for (int i = 0; i < CrcWidth; i++) begin
      r[i] = v[CrcWidth-1-i];
    end
    return r;
  endfunction

  // one table entry worked out on the fly, then merged with the shifted remainder
  function automatic crc_word_t fold_byte(input crc_word_t rem, input crc_byte_t data,
                                          input crc_word_t rpoly);
    crc_word_t v;
    v = {{(CrcWidth-ByteWidth){1'b0}}, rem[ByteWidth-1:0] ^ data};
    for (int i = 0; i < ByteWidth; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ rpoly;
      end else begin
        v = v >> 1;
      end
    end
    return (rem >> ByteWidth) ^ v;
  endfunction

  localparam crc_word_t RPOLY_RESET = reverse32(POLY_RESET);

endpackage

### design/crc32_reflected_prog_poly.sv
// channel  | direction | transfer carries
// ---------+-----------+--------------------------------------------------
// cfg      | in        | cfg_data: generator polynomial, normal bit order
// s_axis   | in        | tdata: data_byte, tuser: first_byte, tlast: last_byte
// m_axis   | out       | tdata: crc_value, tlast: crc_done
//
// one byte per cycle sustained unless the output stalls; the result passes through
// the input register, then the eight-step fold into the result register
// rst is synchronous: polynomial back to 0x1EDC6F41, remainder to all ones
// a stalled output holds its result; the input register still takes one byte
// the polynomial is kept bit-reversed, so the fold path is shift/xor only
module crc32_reflected_prog_poly
  import crc32_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CrcWidth-1:0] cfg_data,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] first_byte
  input  logic                s_axis_tlast,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [CrcWidth-1:0] m_axis_tdata,   // [31:0] crc_value
  output logic                m_axis_tlast
);

  crc_word_t rpoly;
  crc_word_t remainder;
  crc_word_t remainder_next;

  logic      in_valid;
  crc_byte_t in_byte;
  logic      in_first;
  logic      in_last;

  logic      advance;

  assign cfg_ready = 1'b1;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    remainder_next = fold_byte(in_first ? CRC_ALL_ONES : remainder, in_byte, rpoly);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpoly <= RPOLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rpoly <= reverse32(cfg_data);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_first <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
  end

  // remainder moves on only when a byte passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= CRC_ALL_ONES;
    end else if (advance) begin
      remainder <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= remainder_next ^ CRC_ALL_ONES;
      m_axis_tlast <= in_last;
    end
  end

endmodule

### design/crc32_chk.sv
module crc32_chk
  import crc32_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [CrcWidth-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // the generator register never holds off a write
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // an accepted byte moves from the input register to the output when the sink is ready
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after input transfer");

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind crc32_reflected_prog_poly crc32_chk u_crc32_chk (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### test/crc32_reflected_prog_poly_tb.sv
`timescale 1ns / 1ps

module crc32_reflected_prog_poly_tb
  import crc32_pkg::*;
();

  localparam int QUIET_LIMIT  = 400;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 238;
  localparam int DIR_ROWS     = 26;

  typedef enum bit {ROW_BYTE, ROW_POLY} row_kind_t;

  // byte rows carry the data byte in the low bits of word
  typedef struct packed {
    row_kind_t kind;
    crc_word_t word;
    bit        first;
    bit        last;
    bit        known;
    crc_word_t known_crc;
  } dir_row_t;

  typedef struct {
    crc_word_t crc;
    bit        done;
    bit        known;
    crc_word_t known_crc;
  } crc_due_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CrcWidth-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] data_byte
  logic                s_axis_tuser = 1'b0; // [0] first_byte
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [CrcWidth-1:0] m_axis_tdata;        // [31:0] crc_value
  logic                m_axis_tlast;

  // typed-in value travelling alongside the byte being offered
  bit        cur_known = 1'b0;
  crc_word_t cur_known_crc = '0;

  bit        idle_on = 1'b1;
  crc_word_t model_poly;
  crc_word_t model_rem;
  crc_due_t  crc_pending[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        bytes_in = 0;
  int        msgs_closed = 0;
  int        poly_writes = 0;
  int        stall_left = 0;

  dir_row_t directed_rows [0:DIR_ROWS-1] = '{
    // castagnoli generator straight after reset, check string 123456789
    '{ROW_BYTE, 32'h31, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h32, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h33, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h34, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h35, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h36, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h37, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h38, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h39, 1'b0, 1'b1, 1'b1, 32'hE306_9283},
    // no preset after the last byte: carries on from the old remainder
    '{ROW_BYTE, 32'hFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_POLY, 32'h04C1_1DB7, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h31, 1'b1, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h32, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h33, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h34, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h35, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h36, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h37, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h38, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h39, 1'b0, 1'b1, 1'b1, 32'hCBF4_3926},
    // zero generator: the remainder only shifts right a byte at a time
    '{ROW_POLY, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'hFF, 1'b1, 1'b0, 1'b1, 32'hFF00_0000},
    '{ROW_BYTE, 32'h00, 1'b0, 1'b1, 1'b1, 32'hFFFF_0000},
    '{ROW_POLY, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE, 32'h80, 1'b1, 1'b1, 1'b0, 32'h0},
    // left open so the next generator change lands mid-message
    '{ROW_BYTE, 32'h55, 1'b0, 1'b0, 1'b0, 32'h0}
  };

  crc32_reflected_prog_poly dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic crc_word_t mirror_word(input crc_word_t w);
    crc_word_t r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[CrcWidth-1-i] = w[i];
    end
    return r;
  endfunction

  // bit-at-a-time lsb-first update, same result as the table form
  function automatic crc_word_t crc_advance(input crc_word_t rem, input crc_byte_t b,
                                            input crc_word_t rev_poly);
    crc_word_t c;
    c = rem ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ rev_poly) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input crc_word_t want,
                                 input crc_word_t got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // model, checker and watchdog count, all on the rising edge
  always @(posedge clk) begin : track
    crc_due_t due;
    if (rst) begin
      model_poly = POLY_RESET;
      model_rem  = CRC_ALL_ONES;
      crc_pending.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (crc_pending.size() == 0) begin
          report_mismatch("result with nothing pending", '0, m_axis_tdata);
        end else begin
          due = crc_pending.pop_front();
          if (m_axis_tdata !== due.crc) begin
            report_mismatch("crc_value", due.crc, m_axis_tdata);
          end
          if (m_axis_tlast !== due.done) begin
            report_mismatch("crc_done", crc_word_t'(due.done), crc_word_t'(m_axis_tlast));
          end
          if (due.known && m_axis_tdata !== due.known_crc) begin
            report_mismatch("crc_value against known check", due.known_crc, m_axis_tdata);
          end
        end
        if (m_axis_tlast) msgs_closed++;
      end
      if (cfg_valid && cfg_ready) begin
        model_poly = cfg_data;
        poly_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) model_rem = CRC_ALL_ONES;
        model_rem = crc_advance(model_rem, s_axis_tdata, mirror_word(model_poly));
        due.crc       = model_rem ^ CRC_ALL_ONES;
        due.done      = s_axis_tlast;
        due.known     = cur_known;
        due.known_crc = cur_known_crc;
        crc_pending.push_back(due);
        bytes_in++;
      end
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // receiver back-pressure in bursts while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_byte(input crc_byte_t d, input bit f, input bit l,
                           input bit k, input crc_word_t kc);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= f;
    s_axis_tlast  <= l;
    cur_known     <= k;
    cur_known_crc <= kc;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the sender until every result is back, then allow the pipe to settle
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (crc_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_poly(input crc_word_t p);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int len;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_POLY) begin
        write_poly(directed_rows[i].word);
      end else begin
        push_byte(directed_rows[i].word[7:0], directed_rows[i].first,
                  directed_rows[i].last, directed_rows[i].known,
                  directed_rows[i].known_crc);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_poly($urandom);
      idle_on = (ph != PHASES - 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(0, 6) == 0) begin
          // stray byte with arbitrary flags
          push_byte(crc_byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end else begin
          len = $urandom_range(1, 24);
          for (int b = 0; b < len; b++) begin
            push_byte(crc_byte_t'($urandom_range(0, 255)), b == 0, b == len - 1, 1'b0, '0);
          end
          sent += len;
        end
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (crc_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d bytes, %0d closed messages, %0d generator writes",
             bytes_in, msgs_closed, poly_writes);
    $display("including both extreme generators and mid-message generator changes");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/crc32_pkg.sv
design/crc32_reflected_prog_poly.sv
design/crc32_chk.sv
test/crc32_reflected_prog_poly_tb.sv
